### rtl/core/ghtab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghtab_pkg
// shared types and codes of the generational handle table
// ----------------------------------------------------------------------------
package ghtab_pkg;

  localparam int GROUP_W = 32;

  typedef enum logic [2:0] {
    K_CREATE  = 3'd0,
    K_DESTROY = 3'd1,
    K_QUERY   = 3'd2,
    K_MAP     = 3'd3,
    K_UNMAP   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_OK        = 3'd0,
    S_INVALID   = 3'd1,
    S_NOT_FOUND = 3'd2,
    S_STALE     = 3'd3,
    S_BUSY      = 3'd4,
    S_DENIED    = 3'd5,
    S_FULL      = 3'd6,
    S_BAD       = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_READ,
    ST_EXEC
  } state_t;

  localparam int R_READ    = 0;
  localparam int R_WRITE   = 1;
  localparam int R_MAP_CPU = 2;
  localparam int A_READ    = 0;
  localparam int A_WRITE   = 1;

  typedef struct packed {
    logic [31:0] generation;
    logic [3:0]  rights;
    logic        mapped;
    logic [63:0] content_gen;
  } entry_t;

  typedef struct packed {
    logic done;
    logic found;
  } find_stat_t;

endpackage
`default_nettype wire

### rtl/core/generational_handle_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// slot table of generation tagged handles with create, destroy, query, map
// and unmap requests
// ----------------------------------------------------------------------------
// destroy, query, map, unmap and bad requests: entry memory read in ST_READ,
//   then modify, write back and register the result in ST_EXEC (held while
//   the output stalls); the next word is accepted only back in ST_IDLE
// create: a three stage free slot search (ST_FIND) runs ahead of ST_READ and ST_EXEC
// after reset a clearing pass zeroes the entry memory; no word is accepted
//   until it ends
module generational_handle_table import ghtab_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot_code[31:0], handle_generation[63:32], new_rights[67:64],
  // access_request[70:68], zero fill[71]
  input  wire logic [71:0]  s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], out_slot_code[9:3], out_generation[41:10],
  // content_version[105:42], cpu_mapped[106], zero fill[111:107]
  output logic [111:0]      m_axis_tdata
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] clr_cnt;
  logic [2:0]       req_kind;
  logic [31:0]      req_gen;
  logic [3:0]       req_rights;
  logic [2:0]       req_acc;
  logic [IDX_W-1:0] addr;
  logic             pre_valid;
  status_t          pre_status;

  logic [31:0]      in_code;
  logic [31:0]      in_gen;
  logic             in_accept;
  logic             fire;

  logic             find_start;
  find_stat_t       find_stat;
  logic [IDX_W-1:0] free_idx;
  logic             used_rd;
  logic             upd_en;
  logic             upd_val;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             mem_rd_en;
  entry_t           rd_entry;

  status_t          res_status;
  logic [6:0]       res_slot;
  logic [31:0]      res_gen;
  logic [63:0]      res_ver;
  logic             res_map;
  logic             ex_wr;
  entry_t           ex_entry;
  logic [31:0]      gen_inc;
  logic             denied;

  assign in_code   = s_axis_tdata[31:0];
  assign in_gen    = s_axis_tdata[63:32];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign fire      = (state == ST_EXEC) && (!m_axis_tvalid || m_axis_tready);

  ghtab_find #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_find (
    .clk      (clk),
    .rst      (rst),
    .start    (find_start),
    .upd_en   (upd_en),
    .upd_idx  (addr),
    .upd_val  (upd_val),
    .rd_idx   (addr),
    .used_rd  (used_rd),
    .stat     (find_stat),
    .free_idx (free_idx)
  );

  ghtab_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (addr),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    find_start    = 1'b0;
    mem_rd_en     = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == K_CREATE) begin
            find_start = 1'b1;
            state_next = ST_FIND;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_FIND: begin
        if (find_stat.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_rd_en  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_kind   <= s_axis_tuser;
      req_gen    <= in_gen;
      req_rights <= s_axis_tdata[67:64];
      req_acc    <= s_axis_tdata[70:68];
      addr       <= IDX_W'(in_code - 32'd1);
      if (s_axis_tuser == K_CREATE) begin
        pre_valid  <= 1'b0;
        pre_status <= S_OK;
      end else if ((s_axis_tuser == K_MAP && s_axis_tdata[70:68] == 3'd0) ||
                   s_axis_tuser > K_UNMAP) begin
        pre_valid  <= 1'b1;
        pre_status <= S_BAD;
      end else if (in_code == 32'd0 || in_code > 32'(SLOT_COUNT) || in_gen == 32'd0) begin
        pre_valid  <= 1'b1;
        pre_status <= S_INVALID;
      end else begin
        pre_valid  <= 1'b0;
        pre_status <= S_OK;
      end
    end else if (state == ST_FIND && find_stat.done) begin
      addr <= free_idx;
      if (!find_stat.found) begin
        pre_valid  <= 1'b1;
        pre_status <= S_FULL;
      end
    end
  end

  assign gen_inc = rd_entry.generation + 32'd1;
  assign denied  = !rd_entry.rights[R_MAP_CPU] ||
                   (req_acc[A_READ] && !rd_entry.rights[R_READ]) ||
                   (req_acc[A_WRITE] && !rd_entry.rights[R_WRITE]);

  always_comb begin
    res_status = S_OK;
    res_slot   = '0;
    res_gen    = '0;
    res_ver    = '0;
    res_map    = 1'b0;
    ex_wr      = 1'b0;
    ex_entry   = rd_entry;
    upd_en     = 1'b0;
    upd_val    = 1'b0;
    if (pre_valid) begin
      res_status = pre_status;
    end else if (req_kind == K_CREATE) begin
      ex_entry.generation  = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
      ex_entry.rights      = req_rights;
      ex_entry.mapped      = 1'b0;
      ex_entry.content_gen = 64'd1;
      ex_wr    = 1'b1;
      upd_en   = 1'b1;
      upd_val  = 1'b1;
      res_slot = 7'(32'(addr) + 32'd1);
      res_gen  = ex_entry.generation;
    end else if (!used_rd) begin
      res_status = (rd_entry.generation == req_gen) ? S_NOT_FOUND : S_STALE;
    end else if (rd_entry.generation != req_gen) begin
      res_status = S_STALE;
    end else begin
      case (req_kind)
        K_DESTROY: begin
          if (rd_entry.mapped) begin
            res_status = S_BUSY;
          end else begin
            upd_en = 1'b1;
          end
        end
        K_QUERY: begin
          res_ver = rd_entry.content_gen;
          res_map = rd_entry.mapped;
        end
        K_MAP: begin
          if (denied) begin
            res_status = S_DENIED;
          end else if (rd_entry.mapped) begin
            res_status = S_BUSY;
          end else begin
            ex_entry.mapped = 1'b1;
            ex_wr           = 1'b1;
          end
        end
        K_UNMAP: begin
          if (!rd_entry.mapped) begin
            res_status = S_BAD;
          end else begin
            ex_entry.mapped      = 1'b0;
            ex_entry.content_gen = rd_entry.content_gen + 64'd1;
            ex_wr                = 1'b1;
          end
        end
        default: begin
          res_status = S_BAD;
        end
      endcase
    end
    if (!fire) begin
      ex_wr  = 1'b0;
      upd_en = 1'b0;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = ex_wr;
      mem_wr_addr = addr;
      mem_wr_data = ex_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {5'd0, res_map, res_ver, res_gen, res_slot, res_status};
    end
  end

endmodule
`default_nettype wire

### rtl/core/ghtab_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghtab_mem
// slot entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ghtab_mem import ghtab_pkg::*; #(
  parameter int SLOT_COUNT = 64,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/ghtab_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghtab_find
// occupancy bits and a three stage lowest free slot search
// ----------------------------------------------------------------------------
module ghtab_find import ghtab_pkg::*; #(
  parameter int SLOT_COUNT = 64,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             upd_en,
  input  wire logic [IDX_W-1:0] upd_idx,
  input  wire logic             upd_val,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic                  used_rd,
  output find_stat_t            stat,
  output logic [IDX_W-1:0]      free_idx
);

  localparam int NG    = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
  localparam int GRP_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int BIT_W = $clog2(GROUP_W);

  logic [SLOT_COUNT-1:0]   used;
  logic [NG*GROUP_W-1:0]   used_pad;
  logic [NG-1:0]           grp_free;
  logic [GRP_W-1:0]        grp_pick;
  logic [GRP_W-1:0]        grp_q;
  logic                    any_q;
  logic                    any_q2;
  logic [GROUP_W-1:0]      word_q;
  logic [BIT_W-1:0]        bit_pick;
  logic                    v1;
  logic                    v2;
  logic                    v3;

  always_comb begin
    used_pad = '1;
    used_pad[SLOT_COUNT-1:0] = used;
  end

  assign used_rd = used[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (upd_en) begin
      used[upd_idx] <= upd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage one: per group free flags
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_free[g] <= ~&used_pad[g*GROUP_W +: GROUP_W];
    end
  end

  // stage two: lowest group with a free slot
  always_comb begin
    grp_pick = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_pick = GRP_W'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_q  <= grp_pick;
    any_q  <= |grp_free;
    word_q <= used_pad[grp_pick*GROUP_W +: GROUP_W];
  end

  // stage three: lowest free bit in that group
  always_comb begin
    bit_pick = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (!word_q[b]) begin
        bit_pick = BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    free_idx <= IDX_W'({grp_q, bit_pick});
    any_q2   <= any_q;
  end

  assign stat.done  = v3;
  assign stat.found = any_q2;

endmodule
`default_nettype wire
